/* hdl/jet_pkg.sv */
`default_nettype none
package jet_pkg;

    // APB address width: seven registers on 4-byte strides
    localparam int unsigned ApbAddrW = 5;
    localparam int unsigned ApbDataW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MAX_ITER = 3'd0;
    localparam logic [2:0] REG_C_RE     = 3'd1;
    localparam logic [2:0] REG_C_IM     = 3'd2;
    localparam logic [2:0] REG_RE_MIN   = 3'd3;
    localparam logic [2:0] REG_IM_MAX   = 3'd4;
    localparam logic [2:0] REG_RE_STEP  = 3'd5;
    localparam logic [2:0] REG_IM_STEP  = 3'd6;

    // Reset values
    localparam logic [9:0]         MAX_ITER_RST = 10'd100;
    localparam logic signed [31:0] C_RE_RST     = -32'sd157303177;
    localparam logic signed [31:0] C_IM_RST     = 32'sd127238406;
    localparam logic signed [31:0] RE_MIN_RST   = -32'sd402653184;
    localparam logic signed [31:0] IM_MAX_RST   = 32'sd536870912;
    localparam logic [30:0]        RE_STEP_RST  = 31'd787201;
    localparam logic [30:0]        IM_STEP_RST  = 31'd787201;

    // Q4.28 fraction bits and escape threshold 4.0 in Q8.56
    localparam int unsigned QFrac      = 28;
    localparam logic [63:0] ESC_LIMIT  = 64'h0400_0000_0000_0000;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [9:0]         max_iter;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic signed [31:0] re_min;
        logic signed [31:0] im_max;
        logic [30:0]        re_step;
        logic [30:0]        im_step;
    } t_cfg;

    // Clamp a wide signed value into the Q4.28 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX[31:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/jet_mul.sv */
`default_nettype none
module jet_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);

    // One signed 32x32 product per cycle, registered
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

/* hdl/jet_regs.sv */
`default_nettype none
module jet_regs
    import jet_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0]      prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_MAX_ITER: n_cfg.max_iter = pwdata[9:0];
                REG_C_RE:     n_cfg.c_re     = pwdata;
                REG_C_IM:     n_cfg.c_im     = pwdata;
                REG_RE_MIN:   n_cfg.re_min   = pwdata;
                REG_IM_MAX:   n_cfg.im_max   = pwdata;
                REG_RE_STEP:  n_cfg.re_step  = pwdata[30:0];
                REG_IM_STEP:  n_cfg.im_step  = pwdata[30:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter <= MAX_ITER_RST;
            r_cfg.c_re     <= C_RE_RST;
            r_cfg.c_im     <= C_IM_RST;
            r_cfg.re_min   <= RE_MIN_RST;
            r_cfg.im_max   <= IM_MAX_RST;
            r_cfg.re_step  <= RE_STEP_RST;
            r_cfg.im_step  <= IM_STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAX_ITER: prdata = {22'd0, r_cfg.max_iter};
            REG_C_RE:     prdata = r_cfg.c_re;
            REG_C_IM:     prdata = r_cfg.c_im;
            REG_RE_MIN:   prdata = r_cfg.re_min;
            REG_IM_MAX:   prdata = r_cfg.im_max;
            REG_RE_STEP:  prdata = {1'b0, r_cfg.re_step};
            REG_IM_STEP:  prdata = {1'b0, r_cfg.im_step};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/jet_core.sv */
`default_nettype none
module jet_core
    import jet_pkg::*;
#(
    parameter int IMG_WIDTH  = 1024,
    parameter int IMG_HEIGHT = 1024,
    parameter int ITER_BOUND = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [9:0] i_px_col,
    input  wire logic [9:0] i_px_row,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_escaped,
    output logic [9:0]      o_escape_iter
);

    localparam int ColMax = (IMG_WIDTH - 1 > 1023) ? 1023 : IMG_WIDTH - 1;
    localparam int RowMax = (IMG_HEIGHT - 1 > 1023) ? 1023 : IMG_HEIGHT - 1;
    localparam int LimCap = (ITER_BOUND > 1023) ? 1023 : ITER_BOUND;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MAP_RE  = 4'd1;
    localparam logic [3:0] S_MAP_IM  = 4'd2;
    localparam logic [3:0] S_MAP_END = 4'd3;
    localparam logic [3:0] S_SQ_RE   = 4'd4;
    localparam logic [3:0] S_SQ_IM   = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_UPDATE  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [9:0]         r_col, n_col;
    logic [9:0]         r_row, n_row;
    logic [9:0]         r_limit, n_limit;
    logic [9:0]         r_cnt, n_cnt;
    logic signed [31:0] r_zr, n_zr;
    logic signed [31:0] r_zi, n_zi;
    logic signed [63:0] r_rr, n_rr;
    logic signed [63:0] r_ii, n_ii;
    logic               r_esc, n_esc;
    logic [9:0]         r_iter, n_iter;
    logic               r_out_valid, n_out_valid;
    logic               r_escaped, n_escaped;
    logic [9:0]         r_escape_iter, n_escape_iter;

    logic signed [31:0] w_a, w_b;
    logic signed [63:0] w_prod;
    logic [63:0]        w_mod;
    logic signed [63:0] w_diff;
    logic               w_load;

    jet_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_prod)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_escaped     = r_escaped;
    assign o_escape_iter = r_escape_iter;

    assign w_mod  = $unsigned(r_rr) + $unsigned(w_prod);
    assign w_diff = r_rr - r_ii;
    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MAP_RE: begin
                w_a = {22'd0, r_col};
                w_b = {1'b0, i_cfg.re_step};
            end
            S_MAP_IM: begin
                w_a = {22'd0, r_row};
                w_b = {1'b0, i_cfg.im_step};
            end
            S_SQ_IM: begin
                w_a = r_zi;
                w_b = r_zi;
            end
            S_CHECK: begin
                w_a = r_zr;
                w_b = r_zi;
            end
            default: begin
                w_a = r_zr;
                w_b = r_zr;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_limit       = r_limit;
        n_cnt         = r_cnt;
        n_zr          = r_zr;
        n_zi          = r_zi;
        n_rr          = r_rr;
        n_ii          = r_ii;
        n_esc         = r_esc;
        n_iter        = r_iter;
        n_out_valid   = r_out_valid;
        n_escaped     = r_escaped;
        n_escape_iter = r_escape_iter;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_col   = (i_px_col > 10'(ColMax)) ? 10'(ColMax) : i_px_col;
                    n_row   = (i_px_row > 10'(RowMax)) ? 10'(RowMax) : i_px_row;
                    n_limit = (i_cfg.max_iter > 10'(LimCap)) ? 10'(LimCap)
                                                             : i_cfg.max_iter;
                    n_cnt   = '0;
                    n_state = S_MAP_RE;
                end
            end
            S_MAP_RE: begin
                n_state = S_MAP_IM;
            end
            S_MAP_IM: begin
                n_zr    = sat32(64'(i_cfg.re_min) + w_prod);
                n_state = S_MAP_END;
            end
            S_MAP_END: begin
                n_zi    = sat32(64'(i_cfg.im_max) - w_prod);
                n_state = S_SQ_RE;
            end
            S_SQ_RE: begin
                n_state = S_SQ_IM;
            end
            S_SQ_IM: begin
                n_rr    = w_prod;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_ii = w_prod;
                // modulus of the start point is not tested
                if ((r_cnt != '0) && (w_mod > ESC_LIMIT)) begin
                    n_esc   = 1'b1;
                    n_iter  = r_cnt - 10'd1;
                    n_state = S_DONE;
                end else if (r_cnt == r_limit) begin
                    n_esc   = 1'b0;
                    n_iter  = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_zr    = sat32((w_diff >>> QFrac) + 64'(i_cfg.c_re));
                n_zi    = sat32((w_prod >>> (QFrac - 1)) + 64'(i_cfg.c_im));
                n_cnt   = r_cnt + 10'd1;
                n_state = S_SQ_RE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_escaped     = r_esc;
                    n_escape_iter = r_iter;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col         <= n_col;
        r_row         <= n_row;
        r_limit       <= n_limit;
        r_cnt         <= n_cnt;
        r_zr          <= n_zr;
        r_zi          <= n_zi;
        r_rr          <= n_rr;
        r_ii          <= n_ii;
        r_esc         <= n_esc;
        r_iter        <= n_iter;
        r_escaped     <= n_escaped;
        r_escape_iter <= n_escape_iter;
    end

endmodule
`default_nettype wire

/* hdl/julia_escape_time_top.sv */
// Julia set escape-time engine. Each input transaction carries one pixel
// (column, row); the engine maps it to the start point
// z = (re_min + col*re_step) + i*(im_max - row*im_step), all in signed Q4.28,
// and iterates z = z*z + c until the squared modulus (Q8.56) exceeds 4.0 or
// max_iter iterations have run. One output transaction follows per pixel:
// escaped = 1 with the zero-based escape iteration, or escaped = 0 with
// iteration 0. Every value is formed by a single signed 32x32 multiplier
// under a small sequencer: the MAP_RE, MAP_IM and MAP_END states map the
// pixel, then each iteration steps through SQ_RE, SQ_IM, CHECK and UPDATE
// (re^2, im^2, re*im, update), and a last pass through SQ_RE, SQ_IM and
// CHECK tests the final modulus before DONE. The input stalls until the
// engine is back in idle. A finished result sits in an output register,
// so the next pixel is taken while the result waits. Program the
// registers over APB only while the engine is idle.
`default_nettype none
module julia_escape_time_top
    import jet_pkg::*;
#(
    parameter int IMG_WIDTH  = 1024,
    parameter int IMG_HEIGHT = 1024,
    parameter int ITER_BOUND = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0]      prdata,
    output logic                     pready,
    // pixel input
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [9:0]          i_px_col,
    input  wire logic [9:0]          i_px_row,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_escaped,
    output logic [9:0]               o_escape_iter
);

    t_cfg w_cfg;

    // register bank: view bounds, steps, Julia constant, iteration limit
    jet_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer with the shared multiplier and the output register
    jet_core #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .ITER_BOUND (ITER_BOUND)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_px_col      (i_px_col),
        .i_px_row      (i_px_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_escaped     (o_escaped),
        .o_escape_iter (o_escape_iter)
    );

endmodule
`default_nettype wire

/* sim/julia_escape_time_top_test.sv */
`timescale 1ns / 1ps

module julia_escape_time_top_test;
    import jet_pkg::*;

    // Register index with no register behind it; writes there must be dropped
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
    } t_pixel;

    typedef struct packed {
        logic       escaped;
        logic [9:0] escape_iter;
    } t_escape;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    logic       px_valid = 1'b0;
    logic       px_stall;
    logic [9:0] px_col = '0;
    logic [9:0] px_row = '0;

    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       res_escaped;
    logic [9:0] res_escape_iter;

    // Shadow copy of the view registers, updated on every APB write
    logic [9:0]         iter_limit = MAX_ITER_RST;
    logic signed [31:0] c_real     = C_RE_RST;
    logic signed [31:0] c_imag     = C_IM_RST;
    logic signed [31:0] view_left  = RE_MIN_RST;
    logic signed [31:0] view_top   = IM_MAX_RST;
    logic [30:0]        col_pitch  = RE_STEP_RST;
    logic [30:0]        row_pitch  = IM_STEP_RST;

    t_pixel  pending_pixels[$];
    t_escape predicted_escapes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int error_count = 0;

    julia_escape_time_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (px_valid),
        .o_in_stall    (px_stall),
        .i_px_col      (px_col),
        .i_px_row      (px_row),
        .o_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .o_escaped     (res_escaped),
        .o_escape_iter (res_escape_iter)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a wide value back into the signed Q4.28 range
    function automatic longint sat_q428(longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // Map the pixel into the plane and run the escape-time orbit
    function automatic t_escape escape_predict(logic [9:0] col, logic [9:0] row);
        longint      zr, zi, rr, ii, ri, nr, ni;
        logic [63:0] sq_r, sq_i;
        t_escape     res;
        res = '0;
        zr = sat_q428(longint'(view_left) + longint'(col) * longint'(col_pitch));
        zi = sat_q428(longint'(view_top) - longint'(row) * longint'(row_pitch));
        for (int k = 0; k < int'(iter_limit); k++) begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            // 2*re*im comes from one bit less of right shift
            nr = sat_q428(((rr - ii) >>> QFrac) + longint'(c_real));
            ni = sat_q428((ri >>> (QFrac - 1)) + longint'(c_imag));
            zr = nr;
            zi = ni;
            sq_r = zr * zr;
            sq_i = zi * zi;
            if (sq_r + sq_i > ESC_LIMIT) begin
                res.escaped = 1'b1;
                res.escape_iter = 10'(k);
                break;
            end
        end
        return res;
    endfunction

    // Setup phase, then access phase; the register lands on the access edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_ITER: iter_limit = value[9:0];
            REG_C_RE:     c_real = value;
            REG_C_IM:     c_imag = value;
            REG_RE_MIN:   view_left = value;
            REG_IM_MAX:   view_top = value;
            REG_RE_STEP:  col_pitch = value[30:0];
            REG_IM_STEP:  row_pitch = value[30:0];
            default: ;
        endcase
    endtask

    task automatic push_pixel(int col, int row);
        pending_pixels.push_back(t_pixel'{col: 10'(col), row: 10'(row)});
    endtask

    // Hold until every queued pixel went in and every result came out
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || px_valid || predicted_escapes.size() != 0)
            @(negedge clk);
    endtask

    // Pick a view around the interesting part of the plane; now and then
    // throw in raw 32-bit values so every register bit moves
    task automatic random_view();
        logic [31:0] v;
        apb_write(REG_MAX_ITER, 32'($urandom_range(1, 64)));
        v = ($urandom_range(0, 3) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        apb_write(REG_C_RE, v);
        v = ($urandom_range(0, 3) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        apb_write(REG_C_IM, v);
        v = ($urandom_range(0, 7) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h0800_0000) - 32'h2400_0000;
        apb_write(REG_RE_MIN, v);
        v = ($urandom_range(0, 7) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h0800_0000) + 32'h1C00_0000;
        apb_write(REG_IM_MAX, v);
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                        : $urandom_range(32'h4_0000, 32'h20_0000);
        apb_write(REG_RE_STEP, v);
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                        : $urandom_range(32'h4_0000, 32'h20_0000);
        apb_write(REG_IM_STEP, v);
    endtask

    // Driver: offer the next pixel once the current transaction is taken,
    // predicting its result on the accepting edge
    always @(posedge clk) begin
        t_pixel nxt;
        if (!rst_n) begin
            px_valid <= 1'b0;
        end else begin
            if (px_valid && !px_stall) begin
                predicted_escapes.push_back(escape_predict(px_col, px_row));
            end
            if (!px_valid || !px_stall) begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_pixels.pop_front();
                    px_col <= nxt.col;
                    px_row <= nxt.row;
                    px_valid <= 1'b1;
                end else begin
                    px_valid <= 1'b0;
                end
            end
        end
    end

    // Count down a long receiver hold-off
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each accepted result against the oldest prediction
    always @(posedge clk) begin
        t_escape want;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (predicted_escapes.size() == 0) begin
                    $error("unexpected result: escaped %0d, escape_iter %0d",
                           res_escaped, res_escape_iter);
                    error_count++;
                end else begin
                    want = predicted_escapes.pop_front();
                    if (res_escaped !== want.escaped) begin
                        $error("escaped: expected %0d, got %0d", want.escaped, res_escaped);
                        error_count++;
                    end
                    if (res_escape_iter !== want.escape_iter) begin
                        $error("escape_iter: expected %0d, got %0d",
                               want.escape_iter, res_escape_iter);
                        error_count++;
                    end
                end
            end
            res_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Stimulus
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset view: image corners and a couple of inner points
        push_pixel(0, 0);
        push_pixel(1023, 1023);
        push_pixel(0, 1023);
        push_pixel(1023, 0);
        push_pixel(512, 512);
        push_pixel(300, 700);
        wait_idle();

        // Zero limit: no iteration runs at all
        apb_write(REG_MAX_ITER, 32'd0);
        push_pixel(512, 512);
        push_pixel(0, 0);
        wait_idle();

        // Single iteration
        apb_write(REG_MAX_ITER, 32'd1);
        push_pixel(512, 512);
        push_pixel(1023, 1023);
        wait_idle();

        // Bounded orbits at the full limit: c = 0 with |z| < 1 never escapes
        apb_write(REG_MAX_ITER, 32'd1023);
        apb_write(REG_C_RE, 32'd0);
        apb_write(REG_C_IM, 32'd0);
        apb_write(REG_RE_MIN, 32'd0);
        apb_write(REG_IM_MAX, 32'd0);
        apb_write(REG_RE_STEP, 32'h0004_0000);
        apb_write(REG_IM_STEP, 32'h0004_0000);
        // Nothing lives at the last index; this write must not land anywhere
        apb_write(REG_NONE, 32'h1000_0000);
        push_pixel(0, 0);
        push_pixel(1023, 0);
        push_pixel(700, 700);
        wait_idle();

        // Saturated start point and constant: escape on the first iteration
        apb_write(REG_MAX_ITER, 32'd5);
        apb_write(REG_C_RE, 32'h8000_0000);
        apb_write(REG_C_IM, 32'h7FFF_FFFF);
        apb_write(REG_RE_MIN, 32'h7FFF_FFFF);
        apb_write(REG_IM_MAX, 32'h8000_0000);
        apb_write(REG_RE_STEP, 32'h7FFF_FFFF);
        apb_write(REG_IM_STEP, 32'h7FFF_FFFF);
        push_pixel(1023, 1023);
        push_pixel(0, 0);
        push_pixel(1023, 0);
        push_pixel(0, 1023);
        wait_idle();

        // Random views; idling cycles through none, sender, receiver, both
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            random_view();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            // Block the output long enough for the engine to back up
            if (ph == 2) begin
                hold_left = 3000;
            end
            for (int n = 0; n < 130; n++) begin
                // Pause the sender mid-phase until everything has drained
                if (ph == 5 && n == 65) begin
                    wait_idle();
                end
                push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end

        wait_idle();
        repeat (500) @(negedge clk);
        if (error_count == 0) begin
            $display("julia_escape_time_top test passed");
        end else begin
            $display("julia_escape_time_top test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("julia_escape_time_top test failed");
        $finish;
    end

endmodule
